### design/malu_pkg.sv
// ----------------------------------------------------------------------------
// malu_pkg: shared types for the 32-bit ALU
// Operation codes, transfer payloads and inter-stage records.
// ----------------------------------------------------------------------------
`default_nettype none

package malu_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned KindW  = 4;
  localparam int unsigned ShamtW = 5;

  typedef enum logic [KindW-1:0] {
    OP_ADD  = 4'd0,
    OP_ADDU = 4'd1,
    OP_SUB  = 4'd2,
    OP_SUBU = 4'd3,
    OP_SLT  = 4'd4,
    OP_AND  = 4'd5,
    OP_OR   = 4'd6,
    OP_XOR  = 4'd7,
    OP_NOT  = 4'd8,
    OP_NAND = 4'd9,
    OP_NOR  = 4'd10,
    OP_EQ   = 4'd11,
    OP_SLL  = 4'd12,
    OP_SRL  = 4'd13,
    OP_SRA  = 4'd14
  } malu_op_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [DataW-1:0]  operand_a;
    logic [DataW-1:0]  operand_b;
    logic [ShamtW-1:0] shift_amount;
  } malu_req_t;

  typedef struct packed {
    logic [DataW-1:0] result;
    logic             zero_flag;
    logic             overflow_flag;
  } malu_res_t;

  // Stage 1 -> stage 2: raw unit outputs
  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
    logic [DataW-1:0] sum;
    logic             a_msb;
    logic             b_msb;
    logic [DataW-1:0] logic_res;
    logic [DataW-1:0] shift_res;
  } malu_s1_t;

  // Stage 2 -> stage 3: selected result
  typedef struct packed {
    logic             valid;
    logic             is_slt;
    logic             overflow;
    logic [DataW-1:0] result;
  } malu_s2_t;

endpackage

`default_nettype wire

### design/malu_exec.sv
// ----------------------------------------------------------------------------
// malu_exec: first ALU stage
// Adder, logic unit and barrel shifter side by side, outputs registered.
// ----------------------------------------------------------------------------
`default_nettype none

module malu_exec import malu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire malu_req_t req_i,
  output malu_s1_t       s1_o
);

  malu_s1_t         s1_d, s1_q;
  logic             do_sub;
  logic [DataW-1:0] b_eff;

  always_comb begin
    do_sub = (req_i.kind == OP_SUB) || (req_i.kind == OP_SUBU) ||
             (req_i.kind == OP_SLT) || (req_i.kind == OP_EQ);
    b_eff  = do_sub ? ~req_i.operand_b : req_i.operand_b;

    s1_d.valid = valid_i;
    s1_d.kind  = req_i.kind;
    s1_d.sum   = req_i.operand_a + b_eff + {{(DataW-1){1'b0}}, do_sub};
    s1_d.a_msb = req_i.operand_a[DataW-1];
    s1_d.b_msb = b_eff[DataW-1];

    case (req_i.kind)
      OP_AND:  s1_d.logic_res = req_i.operand_a & req_i.operand_b;
      OP_OR:   s1_d.logic_res = req_i.operand_a | req_i.operand_b;
      OP_XOR:  s1_d.logic_res = req_i.operand_a ^ req_i.operand_b;
      OP_NOT:  s1_d.logic_res = ~req_i.operand_b;
      OP_NAND: s1_d.logic_res = ~(req_i.operand_a & req_i.operand_b);
      OP_NOR:  s1_d.logic_res = ~(req_i.operand_a | req_i.operand_b);
      default: s1_d.logic_res = '0;
    endcase

    case (req_i.kind)
      OP_SLL:  s1_d.shift_res = req_i.operand_a << req_i.shift_amount;
      OP_SRL:  s1_d.shift_res = req_i.operand_a >> req_i.shift_amount;
      OP_SRA:  s1_d.shift_res = DataW'($signed(req_i.operand_a) >>> req_i.shift_amount);
      default: s1_d.shift_res = '0;
    endcase
  end

  // Valid bit resets; payload simply follows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q.valid <= 1'b0;
    end else begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

`default_nettype wire

### design/malu_select.sv
// ----------------------------------------------------------------------------
// malu_select: second ALU stage
// Overflow and signed less-than detection, result selection.
// ----------------------------------------------------------------------------
`default_nettype none

module malu_select import malu_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire malu_s1_t s1_i,
  output malu_s2_t      s2_o
);

  malu_s2_t s2_d, s2_q;
  logic     ovf_raw;
  logic     less;

  always_comb begin
    // Same-sign inputs into the adder yet a sign change in the sum
    ovf_raw = (s1_i.a_msb == s1_i.b_msb) && (s1_i.sum[DataW-1] != s1_i.a_msb);
    // b_msb holds the inverted sign of B here; signs differ when equal
    less    = (s1_i.a_msb == s1_i.b_msb) ? s1_i.a_msb : s1_i.sum[DataW-1];

    s2_d.valid    = s1_i.valid;
    s2_d.is_slt   = 1'b0;
    s2_d.overflow = 1'b0;
    s2_d.result   = '0;

    case (s1_i.kind)
      OP_ADD, OP_SUB: begin
        s2_d.overflow = ovf_raw;
        s2_d.result   = ovf_raw ? '0 : s1_i.sum;
      end
      OP_ADDU, OP_SUBU, OP_EQ: begin
        s2_d.result = s1_i.sum;
      end
      OP_SLT: begin
        s2_d.is_slt = 1'b1;
        s2_d.result = {{(DataW-1){1'b0}}, less};
      end
      OP_AND, OP_OR, OP_XOR, OP_NOT, OP_NAND, OP_NOR: begin
        s2_d.result = s1_i.logic_res;
      end
      OP_SLL, OP_SRL, OP_SRA: begin
        s2_d.result = s1_i.shift_res;
      end
      default: begin
        s2_d.result = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q.valid <= 1'b0;
    end else begin
      s2_q <= s2_d;
    end
  end

  assign s2_o = s2_q;

endmodule

`default_nettype wire

### design/malu_flags.sv
// ----------------------------------------------------------------------------
// malu_flags: third ALU stage
// Zero flag generation and the registered result port.
// ----------------------------------------------------------------------------
`default_nettype none

module malu_flags import malu_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire malu_s2_t s2_i,
  output logic          res_valid_o,
  output malu_res_t     res_o
);

  logic      valid_q;
  malu_res_t res_d, res_q;

  always_comb begin
    res_d.result        = s2_i.result;
    res_d.zero_flag     = s2_i.is_slt ? s2_i.result[0] : (s2_i.result == '0);
    res_d.overflow_flag = s2_i.overflow;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s2_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

### design/mips_alu_32bit.sv
// ----------------------------------------------------------------------------
// mips_alu_32bit: three-stage 32-bit execute ALU
// A transfer passes the stage 1, 2 and 3 registers before its result strobe.
// Throughput: one operation per cycle; busy_o stays low, the pipe never stalls.
// The result strobe is high for exactly one cycle per accepted operation.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; data is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_alu_32bit import malu_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  // Command side: transfer when start_i is high and busy_o is low
  input  wire logic      start_i,
  output logic           busy_o,
  input  wire malu_req_t req_i,
  // Result side: one-cycle strobe, the receiver takes it as it comes
  output logic           res_valid_o,
  output malu_res_t      res_o
);

  malu_s1_t s1;
  malu_s2_t s2;
  logic     accept;

  // The receiver cannot push back, so every stage advances every cycle and
  // there is never a reason to refuse a command.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Stage 1: adder (add/sub/compare share it), logic unit, barrel shifter
  malu_exec u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .req_i   (req_i),
    .s1_o    (s1)
  );

  // Stage 2: trap on signed overflow, derive set-less-than, pick the result
  malu_select u_select (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .s1_i   (s1),
    .s2_o   (s2)
  );

  // Stage 3: zero detect (full word, bit 0 for SLT), drive the result register
  malu_flags u_flags (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s2_i        (s2),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

### verif/tb_mips_alu_32bit.sv
// ----------------------------------------------------------------------------
// tb_mips_alu_32bit: self-checking bench for the three-stage 32-bit ALU
// Drive operations through the start/busy port in bursts with random gaps.
// Predict each result in a ledger class and compare every strobed result
// with the oldest prediction, field by field. A directed set covers
// overflow, wrap, compare and shift corners. A random set follows.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_mips_alu_32bit;
  import malu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Spare operation code: the block must give zero with the zero flag set.
  localparam logic [KindW-1:0] KindSpare  = 4'hF;
  localparam int unsigned      NumRandom  = 550;
  // Idle limit in cycles. The longest legal quiet stretch is a sender gap
  // plus the pipe latency, far below this.
  localparam int unsigned      StallLimit = 2000;

  // --------------------------------------------------------------------------
  // Ledger of predicted ALU results, oldest first
  // --------------------------------------------------------------------------
  class alu_ledger;
    malu_res_t awaited[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // Work out the result of one operation at the block's widths.
    function malu_res_t alu_outcome(malu_req_t r);
      malu_res_t        o;
      logic [DataW-1:0] a, b, v;
      logic             ovf;
      a   = r.operand_a;
      b   = r.operand_b;
      v   = '0;
      ovf = 1'b0;
      case (r.kind)
        OP_ADD: begin
          v = a + b;
          if (a[DataW-1] == b[DataW-1] && v[DataW-1] != a[DataW-1]) begin
            ovf = 1'b1;
            v   = '0;
          end
        end
        OP_ADDU: v = a + b;
        OP_SUB: begin
          v = a - b;
          if (a[DataW-1] != b[DataW-1] && v[DataW-1] != a[DataW-1]) begin
            ovf = 1'b1;
            v   = '0;
          end
        end
        OP_SUBU: v = a - b;
        OP_SLT:  v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        OP_AND:  v = a & b;
        OP_OR:   v = a | b;
        OP_XOR:  v = a ^ b;
        OP_NOT:  v = ~b;
        OP_NAND: v = ~(a & b);
        OP_NOR:  v = ~(a | b);
        OP_EQ:   v = a - b;
        OP_SLL:  v = a << r.shift_amount;
        OP_SRL:  v = a >> r.shift_amount;
        OP_SRA:  v = $signed(a) >>> r.shift_amount;
        default: v = '0;
      endcase
      o.result        = v;
      o.zero_flag     = (r.kind == OP_SLT) ? v[0] : (v == '0);
      o.overflow_flag = ovf;
      return o;
    endfunction

    function void note_issue(malu_req_t r);
      awaited.push_back(alu_outcome(r));
    endfunction

    function void check_result(malu_res_t got);
      malu_res_t want;
      if (awaited.size() == 0) begin
        $display("%0t: result with nothing awaited: result %h zero %b ovf %b",
                 $time, got.result, got.zero_flag, got.overflow_flag);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.result !== want.result) begin
        $display("%0t: result mismatch: expected %h, actual %h",
                 $time, want.result, got.result);
        errors++;
      end
      if (got.zero_flag !== want.zero_flag) begin
        $display("%0t: zero flag mismatch: expected %b, actual %b",
                 $time, want.zero_flag, got.zero_flag);
        errors++;
      end
      if (got.overflow_flag !== want.overflow_flag) begin
        $display("%0t: overflow flag mismatch: expected %b, actual %b",
                 $time, want.overflow_flag, got.overflow_flag);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, DUT signals and instance
  // --------------------------------------------------------------------------
  logic      clk_i;
  logic      rst_ni;
  logic      start_i;
  logic      busy_o;
  malu_req_t req_i;
  logic      res_valid_o;
  malu_res_t res_o;

  alu_ledger ledger;
  int        quiet_cycles;
  int        burst_left;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  mips_alu_32bit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  // --------------------------------------------------------------------------
  // Monitor: sample at the rising edge, before the DUT's registers update.
  // Check the strobed result first, then note the transfer of this edge,
  // since the pipe cannot return a result in the cycle it takes the operation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_valid_o) ledger.check_result(res_o);
      if (start_i && !busy_o) ledger.note_issue(req_i);
    end
  end

  // Watchdog: count cycles without any transfer or result strobe.
  always @(posedge clk_i) begin
    if (rst_ni && ((start_i && !busy_o) || res_valid_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks
  // --------------------------------------------------------------------------

  // Present one operation at the falling edge and hold it until the
  // block takes the transfer.
  task automatic issue(input malu_req_t r);
    @(negedge clk_i);
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Drop start over a gap set by n, with junk on the payload to prove it is ignored.
  task automatic hold_off(input int unsigned n);
    logic [95:0] junk;
    if (n > 0) begin
      junk = {$urandom, $urandom, $urandom};
      @(negedge clk_i);
      start_i <= 1'b0;
      req_i   <= junk[$bits(malu_req_t)-1:0];
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // Issue one operation, then idle when the current burst runs out.
  // Roughly a quarter of the bursts have no gap behind them, so long
  // back-to-back stretches occur too.
  task automatic issue_paced(input malu_req_t r);
    issue(r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) hold_off($urandom_range(1, 12));
    end
  endtask

  // Lower start and wait until every awaited result has come back.
  task automatic drain();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
  endtask

  function automatic malu_req_t make_op(input logic [KindW-1:0] k,
                                        input logic [DataW-1:0] a,
                                        input logic [DataW-1:0] b,
                                        input logic [ShamtW-1:0] sh);
    malu_req_t r;
    r.kind         = k;
    r.operand_a    = a;
    r.operand_b    = b;
    r.shift_amount = sh;
    return r;
  endfunction

  // Operand source: full random three times in eight, else zero, a small value
  // or a value at or close to the signed and unsigned boundaries, so overflow
  // and wrap cases turn up often under add and sub.
  function automatic logic [DataW-1:0] pick_operand();
    logic [DataW-1:0] v;
    case ($urandom_range(0, 7))
      0: v = 32'h0000_0000;
      1: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: v = 32'h8000_0000 + $urandom_range(0, 3);
      3: v = 32'hFFFF_FFFF - $urandom_range(0, 3);
      4: v = $urandom_range(0, 15);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    malu_req_t    r;
    logic [KindW-1:0] k;
    logic [DataW-1:0] a;

    ledger       = new();
    quiet_cycles = 0;
    burst_left   = 0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: trapping overflow both ways, wrap of the unsigned forms,
    // signed compare across the sign boundary, every logic operation,
    // equality hit and miss, shift extremes and the spare code.
    issue(make_op(OP_ADD,  32'h7FFF_FFFF, 32'h0000_0001, 5'd0));
    issue(make_op(OP_ADD,  32'h8000_0000, 32'hFFFF_FFFF, 5'd31));
    issue(make_op(OP_ADD,  32'h1234_5678, 32'h0000_0001, 5'd0));
    issue(make_op(OP_ADD,  32'hFFFF_FFFF, 32'h0000_0001, 5'd7));
    issue(make_op(OP_ADDU, 32'hFFFF_FFFF, 32'h0000_0001, 5'd0));
    issue(make_op(OP_ADDU, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd0));
    issue(make_op(OP_SUB,  32'h8000_0000, 32'h0000_0001, 5'd0));
    issue(make_op(OP_SUB,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 5'd0));
    issue(make_op(OP_SUB,  32'h0000_0005, 32'h0000_0005, 5'd0));
    issue(make_op(OP_SUBU, 32'h0000_0000, 32'h0000_0001, 5'd0));
    issue(make_op(OP_SLT,  32'h8000_0000, 32'h7FFF_FFFF, 5'd0));
    issue(make_op(OP_SLT,  32'h7FFF_FFFF, 32'h8000_0000, 5'd0));
    issue(make_op(OP_SLT,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0));
    issue(make_op(OP_AND,  32'hFFFF_FFFF, 32'h0000_0000, 5'd0));
    issue(make_op(OP_OR,   32'hA5A5_A5A5, 32'h5A5A_5A5A, 5'd0));
    issue(make_op(OP_XOR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0));
    issue(make_op(OP_NOT,  32'h0000_0000, 32'h0000_0000, 5'd0));
    issue(make_op(OP_NAND, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd0));
    issue(make_op(OP_NOR,  32'h0000_0000, 32'h0000_0000, 5'd0));
    issue(make_op(OP_EQ,   32'hDEAD_BEEF, 32'hDEAD_BEEF, 5'd0));
    issue(make_op(OP_EQ,   32'h0000_0000, 32'hFFFF_FFFF, 5'd0));
    issue(make_op(OP_SLL,  32'hFFFF_FFFF, 32'h0000_0000, 5'd31));
    issue(make_op(OP_SRL,  32'hFFFF_FFFF, 32'h0000_0000, 5'd31));
    issue(make_op(OP_SRA,  32'h8000_0000, 32'h0000_0000, 5'd31));
    issue(make_op(OP_SRA,  32'h8000_0001, 32'h0000_0000, 5'd0));
    issue(make_op(KindSpare, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31));

    // Hold the sender until the pipe has emptied completely.
    drain();

    // Random: mostly valid codes, the spare code now and then.
    repeat (NumRandom) begin
      if ($urandom_range(0, 31) == 0) k = KindSpare;
      else                            k = KindW'($urandom_range(0, 14));
      a = pick_operand();
      r = make_op(k, a, pick_operand(), ShamtW'($urandom_range(0, 31)));
      // Equality hits are rare with random operands; force some.
      if (k == OP_EQ && $urandom_range(0, 2) == 0) r.operand_b = a;
      issue_paced(r);
    end

    // Wait out the last results, then a margin beyond the pipe latency
    // so that a stray strobe would still be caught.
    drain();
    repeat (8) @(posedge clk_i);

    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
design/malu_pkg.sv
design/malu_exec.sv
design/malu_select.sv
design/malu_flags.sv
design/mips_alu_32bit.sv
verif/tb_mips_alu_32bit.sv
